// ===== design/bcd_pkg.sv =====
package bcd_pkg;

    localparam int NUM_HEADERS_DEF = 16;
    localparam int NUM_BUCKETS_DEF = 4;
    localparam int BLOCK_BITS_DEF  = 16;

    localparam int CMD_W    = 3;
    localparam int BLOCK_W  = 16;
    localparam int INDEX_W  = 4;
    localparam int STATUS_W = 6;

    localparam int IN_BITS  = CMD_W + BLOCK_W + INDEX_W + 2 * STATUS_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = 1 + INDEX_W + BLOCK_W + STATUS_W + 1;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOOKUP      = 3'd0,
        CMD_HASH_APPEND = 3'd1,
        CMD_HASH_UNLINK = 3'd2,
        CMD_FREE_HEAD   = 3'd3,
        CMD_FREE_TAIL   = 3'd4,
        CMD_FREE_UNLINK = 3'd5,
        CMD_OLDEST      = 3'd6,
        CMD_STATUS      = 3'd7
    } cmd_t;

    localparam logic [STATUS_W-1:0] LOCKED_BIT = 6'b000001;

endpackage

// ===== design/buffer_cache_directory.sv =====
// buffer cache directory: hash chains and lru free list over a pool of headers
//
// s_axis carries one command word; m_axis returns exactly one result word per
// command, in order. s_axis_tready is high only while the block is idle, so one
// command is in work at a time.
//
// list edits and status access go from accept through the exec and report
// states to the result; lookup puts the walk state between them and leaves it
// on a hit, at the end of the chain or at the step bound; the chain walk
// reads one header per cycle through a single next-pointer read.
//
// reset clears every chain and the free list and zeroes all status bits; block
// numbers of headers never appended are undefined.
// a stalled receiver holds the result in the output register; the next
// command is taken only after the result word leaves.
module buffer_cache_directory #(
    parameter int NUM_HEADERS = bcd_pkg::NUM_HEADERS_DEF,
    parameter int NUM_BUCKETS = bcd_pkg::NUM_BUCKETS_DEF,
    parameter int BLOCK_BITS  = bcd_pkg::BLOCK_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // command[2:0], block_number[18:3], header_index[22:19],
    // status_value[28:23], status_mask[34:29], zero fill
    input  logic [bcd_pkg::IN_W-1:0] s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // found[0], result_index[4:1], result_block[20:5], result_status[26:21],
    // free_empty[27], zero fill
    output logic [bcd_pkg::OUT_W-1:0] m_axis_tdata
);

    localparam int HW = (NUM_HEADERS > 1) ? $clog2(NUM_HEADERS) : 1;
    localparam int LW = $clog2(NUM_HEADERS + 1);
    localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam logic [LW-1:0] NIL = LW'(NUM_HEADERS);
    localparam int SW = bcd_pkg::STATUS_W;

    typedef enum logic [2:0] {
        ST_IDLE, ST_EXEC, ST_WALK, ST_REPORT, ST_OUT
    } state_t;

    state_t state_reg;

    logic [BLOCK_BITS-1:0] blk_mem   [NUM_HEADERS];
    logic [SW-1:0]         stat_reg  [NUM_HEADERS];
    logic [LW-1:0]         cnext_reg [NUM_HEADERS];
    logic [LW-1:0]         cprev_reg [NUM_HEADERS];
    logic [LW-1:0]         fnext_reg [NUM_HEADERS];
    logic [LW-1:0]         fprev_reg [NUM_HEADERS];
    logic [NUM_HEADERS-1:0] on_chain_reg, on_free_reg;
    logic [LW-1:0]         bfirst_reg [NUM_BUCKETS];
    logic [LW-1:0]         blast_reg  [NUM_BUCKETS];
    logic [LW-1:0]         ffirst_reg, flast_reg;

    logic [bcd_pkg::CMD_W-1:0] cmd_reg;
    logic [BLOCK_BITS-1:0]     blk_reg;
    logic [bcd_pkg::INDEX_W-1:0] idx_reg;
    logic [SW-1:0]             sval_reg, smask_reg;
    logic [LW-1:0]             ptr_reg;
    logic [LW-1:0]             steps_reg;
    logic [bcd_pkg::OUT_W-1:0] out_reg;

    logic [bcd_pkg::CMD_W-1:0]   in_cmd;
    logic [bcd_pkg::BLOCK_W-1:0] in_blk16;
    logic [BLOCK_BITS-1:0]       in_blk;
    logic [bcd_pkg::INDEX_W-1:0] in_idx;
    logic [BW-1:0]               bkt;
    logic [HW-1:0]               h, p;
    logic                        idx_ok;

    assign in_cmd   = s_axis_tdata[2:0];
    assign in_blk16 = s_axis_tdata[18:3];
    assign in_idx   = s_axis_tdata[22:19];
    generate
        if (BLOCK_BITS >= bcd_pkg::BLOCK_W) begin : g_wide
            assign in_blk = BLOCK_BITS'(in_blk16);
        end else begin : g_narrow
            assign in_blk = in_blk16[BLOCK_BITS-1:0];
        end
    endgenerate

    assign bkt    = BW'(blk_reg % NUM_BUCKETS);
    assign idx_ok = ({{(32-bcd_pkg::INDEX_W){1'b0}}, idx_reg} < 32'(NUM_HEADERS));
    assign h      = HW'(idx_reg);
    assign p      = ptr_reg[HW-1:0];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = out_reg;

    // result word for header r
    function automatic logic [bcd_pkg::OUT_W-1:0] pack_res(
        input logic hit, input logic [LW-1:0] r, input logic [BLOCK_BITS-1:0] b,
        input logic [SW-1:0] s, input logic fe);
        logic [bcd_pkg::OUT_W-1:0] w;
        logic [31:0] b32;
        begin
            w   = '0;
            b32 = 32'(b);
            if (hit) begin
                w[0]     = 1'b1;
                w[4:1]   = r[bcd_pkg::INDEX_W-1:0];
                w[20:5]  = b32[15:0];
                w[26:21] = s;
            end
            w[27] = fe;
            return w;
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            on_chain_reg <= '0;
            on_free_reg  <= '0;
            ffirst_reg   <= NIL;
            flast_reg    <= NIL;
            for (int i = 0; i < NUM_HEADERS; i++)
            begin
                stat_reg[i]  <= '0;
                cnext_reg[i] <= NIL;
                cprev_reg[i] <= NIL;
                fnext_reg[i] <= NIL;
                fprev_reg[i] <= NIL;
            end
            for (int i = 0; i < NUM_BUCKETS; i++)
            begin
                bfirst_reg[i] <= NIL;
                blast_reg[i]  <= NIL;
            end
            out_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        cmd_reg   <= in_cmd;
                        blk_reg   <= in_blk;
                        idx_reg   <= in_idx;
                        sval_reg  <= s_axis_tdata[28:23];
                        smask_reg <= s_axis_tdata[34:29];
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    steps_reg <= '0;
                    if (cmd_reg == bcd_pkg::CMD_LOOKUP)
                    begin
                        ptr_reg   <= bfirst_reg[bkt];
                        state_reg <= ST_WALK;
                    end
                    else
                    begin
                        state_reg <= ST_REPORT;
                        if (cmd_reg == bcd_pkg::CMD_OLDEST)
                            ptr_reg <= ffirst_reg;
                        else if (!idx_ok)
                            ptr_reg <= NIL;
                        else
                        begin
                            ptr_reg <= LW'(idx_reg);
                            case (cmd_reg)
                                bcd_pkg::CMD_HASH_APPEND:
                                    if (!on_chain_reg[h])
                                    begin
                                        blk_mem[h]   <= blk_reg;
                                        cprev_reg[h] <= blast_reg[bkt];
                                        cnext_reg[h] <= NIL;
                                        if (blast_reg[bkt] != NIL)
                                            cnext_reg[blast_reg[bkt][HW-1:0]] <= LW'(idx_reg);
                                        else
                                            bfirst_reg[bkt] <= LW'(idx_reg);
                                        blast_reg[bkt]  <= LW'(idx_reg);
                                        on_chain_reg[h] <= 1'b1;
                                    end
                                bcd_pkg::CMD_HASH_UNLINK:
                                    if (on_chain_reg[h])
                                    begin
                                        if (cprev_reg[h] != NIL)
                                            cnext_reg[cprev_reg[h][HW-1:0]] <= cnext_reg[h];
                                        else
                                            bfirst_reg[BW'(blk_mem[h] % NUM_BUCKETS)]
                                                <= cnext_reg[h];
                                        if (cnext_reg[h] != NIL)
                                            cprev_reg[cnext_reg[h][HW-1:0]] <= cprev_reg[h];
                                        else
                                            blast_reg[BW'(blk_mem[h] % NUM_BUCKETS)]
                                                <= cprev_reg[h];
                                        cnext_reg[h]    <= NIL;
                                        cprev_reg[h]    <= NIL;
                                        on_chain_reg[h] <= 1'b0;
                                    end
                                bcd_pkg::CMD_FREE_HEAD:
                                    if (!on_free_reg[h])
                                    begin
                                        stat_reg[h]  <= stat_reg[h] & ~bcd_pkg::LOCKED_BIT;
                                        fprev_reg[h] <= NIL;
                                        fnext_reg[h] <= ffirst_reg;
                                        if (ffirst_reg != NIL)
                                            fprev_reg[ffirst_reg[HW-1:0]] <= LW'(idx_reg);
                                        else
                                            flast_reg <= LW'(idx_reg);
                                        ffirst_reg     <= LW'(idx_reg);
                                        on_free_reg[h] <= 1'b1;
                                    end
                                bcd_pkg::CMD_FREE_TAIL:
                                    if (!on_free_reg[h])
                                    begin
                                        stat_reg[h]  <= stat_reg[h] & ~bcd_pkg::LOCKED_BIT;
                                        fnext_reg[h] <= NIL;
                                        fprev_reg[h] <= flast_reg;
                                        if (flast_reg != NIL)
                                            fnext_reg[flast_reg[HW-1:0]] <= LW'(idx_reg);
                                        else
                                            ffirst_reg <= LW'(idx_reg);
                                        flast_reg      <= LW'(idx_reg);
                                        on_free_reg[h] <= 1'b1;
                                    end
                                bcd_pkg::CMD_FREE_UNLINK:
                                    if (on_free_reg[h])
                                    begin
                                        stat_reg[h] <= stat_reg[h] | bcd_pkg::LOCKED_BIT;
                                        if (fprev_reg[h] != NIL)
                                            fnext_reg[fprev_reg[h][HW-1:0]] <= fnext_reg[h];
                                        else
                                            ffirst_reg <= fnext_reg[h];
                                        if (fnext_reg[h] != NIL)
                                            fprev_reg[fnext_reg[h][HW-1:0]] <= fprev_reg[h];
                                        else
                                            flast_reg <= fprev_reg[h];
                                        fnext_reg[h]   <= NIL;
                                        fprev_reg[h]   <= NIL;
                                        on_free_reg[h] <= 1'b0;
                                    end
                                default:
                                    stat_reg[h] <= (stat_reg[h] & ~smask_reg)
                                                 | (sval_reg & smask_reg);
                            endcase
                        end
                    end
                end
                ST_WALK:
                begin
                    // one link per cycle
                    if (ptr_reg == NIL || steps_reg == LW'(NUM_HEADERS))
                    begin
                        ptr_reg   <= NIL;
                        state_reg <= ST_REPORT;
                    end
                    else if (blk_mem[p] == blk_reg)
                        state_reg <= ST_REPORT;
                    else
                    begin
                        ptr_reg   <= cnext_reg[p];
                        steps_reg <= steps_reg + 1'b1;
                    end
                end
                ST_REPORT:
                begin
                    out_reg   <= pack_res(ptr_reg != NIL, ptr_reg, blk_mem[p],
                                          stat_reg[p], ffirst_reg == NIL);
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (m_axis_tready)
                        state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    a_free_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (ffirst_reg == NIL) == (flast_reg == NIL))
        else $error("free list head and tail disagree");

    a_free_count: assert property (@(posedge clk) disable iff (!rst_n)
        (ffirst_reg == NIL) == (on_free_reg == '0))
        else $error("free list empty flag mismatch");

    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second command taken while busy");

    a_out_after_report: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg) == ST_REPORT)
        else $error("result without report");

endmodule
